// ----- rtl/elfc_pkg.sv -----
// ============================================================================
// elfc_pkg: shared types and constants of the escaped length frame checker
// Field widths, the result request layout and the reset escape value.
// ============================================================================
`default_nettype none

package elfc_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;

    localparam logic [BYTE_W-1:0] ESC_RESET = 8'd126;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic              frame_end;
        logic              checksum_pass;
    } t_result;

    // Decoder to output buffer: one optional result request per cycle.
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_dec_out;

endpackage

`default_nettype wire

// ----- rtl/elfc_if.sv -----
// ============================================================================
// elfc_if: stream channels of the escaped length frame checker
// Byte input channel and frame result channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface elfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface elfc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [8:0] byte_position;
    logic       frame_end;
    logic       checksum_pass;

    modport source (output valid, output frame_byte, output byte_position,
                    output frame_end, output checksum_pass, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input frame_end, input checksum_pass, output ready);
endinterface

`default_nettype wire

// ----- rtl/elfc_decoder.sv -----
// ============================================================================
// elfc_decoder: escape and length framing state machine
// Unescapes one byte per accepted request, tracks the frame and its sum.
// ============================================================================
`default_nettype none

module elfc_decoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire [7:0]             i_rx_byte,
    input  wire [7:0]             i_escape_byte,
    output elfc_pkg::t_dec_out    o_res
);
    import elfc_pkg::*;

    logic               r_escape_pending, n_escape_pending;
    logic               r_in_frame,       n_in_frame;
    logic [POS_W-1:0]   r_bytes_remaining, n_bytes_remaining;
    logic [BYTE_W-1:0]  r_running_sum,    n_running_sum;
    logic [POS_W-1:0]   r_position_count, n_position_count;

    logic is_esc;
    logic do_store;
    logic do_start;
    logic last_byte;

    assign is_esc    = (i_rx_byte == i_escape_byte);
    assign do_start  = r_escape_pending && !is_esc;
    assign do_store  = r_in_frame && ((r_escape_pending && is_esc) ||
                                      (!r_escape_pending && !is_esc));
    assign last_byte = (r_bytes_remaining <= POS_W'(1));

    always_comb begin
        n_escape_pending  = r_escape_pending;
        n_in_frame        = r_in_frame;
        n_bytes_remaining = r_bytes_remaining;
        n_running_sum     = r_running_sum;
        n_position_count  = r_position_count;
        o_res             = '0;
        o_res.data.frame_byte = i_rx_byte;
        if (i_accept) begin
            n_escape_pending = !r_escape_pending && is_esc;
            if (do_start) begin
                n_in_frame        = 1'b1;
                n_position_count  = POS_W'(1);
                n_running_sum     = i_rx_byte;
                n_bytes_remaining = {1'b0, i_rx_byte} + POS_W'(1);
                o_res.valid              = 1'b1;
                o_res.data.byte_position = POS_W'(1);
            end else if (do_store) begin
                n_position_count         = r_position_count + POS_W'(1);
                o_res.valid              = 1'b1;
                o_res.data.byte_position = n_position_count;
                if (last_byte) begin
                    o_res.data.frame_end     = 1'b1;
                    o_res.data.checksum_pass = (r_running_sum == i_rx_byte);
                    n_in_frame               = 1'b0;
                    n_bytes_remaining        = '0;
                end else begin
                    n_running_sum     = r_running_sum + i_rx_byte;
                    n_bytes_remaining = r_bytes_remaining - POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending  <= 1'b0;
            r_in_frame        <= 1'b0;
            r_bytes_remaining <= '0;
            r_running_sum     <= '0;
            r_position_count  <= '0;
        end else begin
            r_escape_pending  <= n_escape_pending;
            r_in_frame        <= n_in_frame;
            r_bytes_remaining <= n_bytes_remaining;
            r_running_sum     <= n_running_sum;
            r_position_count  <= n_position_count;
        end
    end

    // An open frame always owes at least its checksum byte.
    a_open_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame == (r_bytes_remaining != '0))
        else $error("frame open flag and remaining count disagree");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.frame_end |=> !r_in_frame)
        else $error("frame still open after frame end");

    a_pending_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_escape_pending |=> !r_escape_pending)
        else $error("escape pending survived the following byte");

    a_silent_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !r_escape_pending && is_esc |-> !o_res.valid)
        else $error("lone escape produced a result");

endmodule

`default_nettype wire

// ----- rtl/elfc_out_buf.sv -----
// ============================================================================
// elfc_out_buf: two-entry result buffer
// Decouples result delivery from byte intake; full only when both entries hold.
// ============================================================================
`default_nettype none

module elfc_out_buf (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  elfc_pkg::t_dec_out    i_res,
    output logic                  o_full,
    output logic                  o_valid,
    output elfc_pkg::t_result     o_data,
    input  wire                   i_ready
);
    import elfc_pkg::*;

    t_result    r_data [2];
    logic [1:0] r_valid;

    logic push;
    logic pop;

    assign o_full  = r_valid[1];
    assign o_valid = r_valid[0];
    assign o_data  = r_data[0];
    assign push    = i_res.valid && !r_valid[1];
    assign pop     = r_valid[0] && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 2'b00;
        end else if (pop) begin
            if (r_valid[1]) begin
                r_valid <= 2'b01;
            end else begin
                r_valid <= {1'b0, push};
            end
        end else if (push) begin
            r_valid <= r_valid[0] ? 2'b11 : 2'b01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_valid[1]) begin
                r_data[0] <= r_data[1];
            end else if (push) begin
                r_data[0] <= i_res.data;
            end
        end else if (push) begin
            if (r_valid[0]) begin
                r_data[1] <= i_res.data;
            end else begin
                r_data[0] <= i_res.data;
            end
        end
    end

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[1] || r_valid[0])
        else $error("second entry filled ahead of the first");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] && !i_ready |=> r_valid[1] && $stable(r_data[0]))
        else $error("full buffer changed without a pop");

    a_shift_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[1] && i_ready |=> r_valid[0] && !r_valid[1]
                                  && r_data[0] == $past(r_data[1]))
        else $error("second entry lost on pop");

endmodule

`default_nettype wire

// ----- rtl/escaped_length_frame_checker.sv -----
// ============================================================================
// escaped_length_frame_checker: byte stream frame recovery and checksum check
// Top level: intake handshake, escape register, decoder and result buffer.
// ============================================================================
// One raw byte is taken per cycle whenever i_rx.ready is high; each accepted
// byte is decoded in the same cycle it is taken and yields zero or one result
// request, so sustained throughput is one byte per clock. Results reach
// o_frame in order from the two-entry result buffer, which registers them
// and sits between the decoder and o_frame: i_rx.ready drops only while
// both entries hold results the sink has not taken. A frame is ESC, length L,
// L data bytes and a checksum; ESC ESC is a literal ESC, ESC followed by any
// other byte opens a new frame with that byte as its length. Every stored
// byte comes out with its position (1 for the length, L+2 for the checksum);
// the checksum byte also carries frame_end and, when the low 8 bits of the
// length plus data match it, checksum_pass. The escape value resets to 126;
// the user rewrites it via i_cfg_we / i_cfg_data only while idle (unenforced).
// ============================================================================
`default_nettype none

module escaped_length_frame_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data,
    elfc_rx_if.sink    i_rx,
    elfc_frame_if.source o_frame
);
    import elfc_pkg::*;

    logic [BYTE_W-1:0] r_escape_byte;
    logic              accept;
    logic              buf_full;
    t_dec_out          dec_res;
    t_result           out_data;

    // Escape value register; the host must write it only between frames (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_byte <= ESC_RESET;
        end else if (i_cfg_we) begin
            r_escape_byte <= i_cfg_data;
        end
    end

    // Intake stalls only when the result buffer is full.
    assign i_rx.ready = !buf_full;
    assign accept     = i_rx.valid && !buf_full;

    elfc_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx.rx_byte),
        .i_escape_byte (r_escape_byte),
        .o_res         (dec_res)
    );

    elfc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (dec_res),
        .o_full  (buf_full),
        .o_valid (o_frame.valid),
        .o_data  (out_data),
        .i_ready (o_frame.ready)
    );

    assign o_frame.frame_byte    = out_data.frame_byte;
    assign o_frame.byte_position = out_data.byte_position;
    assign o_frame.frame_end     = out_data.frame_end;
    assign o_frame.checksum_pass = out_data.checksum_pass;

    // A result request is never produced while the buffer cannot take it.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_res.valid |-> !buf_full)
        else $error("result produced while buffer full");

    a_pass_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid && o_frame.checksum_pass |-> o_frame.frame_end)
        else $error("checksum pass without frame end");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid |-> o_frame.byte_position != '0)
        else $error("result with zero position");

endmodule

`default_nettype wire
